/* rtl/assert_macros.svh */
// assertion helpers, clocked on i_clk, quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define PFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pfp_pkg.sv */
package pfp_pkg;
    localparam int MOD_BITS_DEF = 32;
    localparam int EXP_W        = 64;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = $clog2(EXP_W);
endpackage

/* rtl/pfp_modred.sv */
module pfp_modred
    import pfp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [EXP_W-1:0]    i_dividend,
    input  logic [MOD_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_rem
);
    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [EXP_W-1:0]    r_val;
    logic [MOD_BITS-1:0] r_rem;
    logic [MOD_BITS-1:0] r_div;
    logic [MOD_BITS:0]   w_trial;
    logic [MOD_BITS:0]   w_diff;
    logic [MOD_BITS-1:0] n_rem;

    // one restoring step per cycle while busy, msb of the dividend first
    always_comb begin
        w_trial = {r_rem, r_val[EXP_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[MOD_BITS-1:0];
        end else begin
            n_rem = w_trial[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_val  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(EXP_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_val <= {r_val[EXP_W-2:0], 1'b0};
                r_rem <= n_rem;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

/* rtl/prime_field_power_top.sv */
// base out of range or base 0 or 1: no reduction, the sequencer goes from S_IDLE to S_OUT
// general case: exponent reduction modulo the modulus minus one, then one reduction per
//   modular product, up to 2*(MOD_BITS-1) products
// each reduction is a one-bit-per-cycle restoring remainder over 64 bits in pfp_modred
// throughput: one transaction at a time; input ready only while the sequencer is idle
// reset: synchronous active low, modulus returns to 2, no result pending
module prime_field_power_top
    import pfp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [DATA_W-1:0]       i_cfg_wr_data,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [DATA_W+EXP_W-1:0] i_s_axis_tdata,  // base[31:0], exponent[95:32]
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [DATA_W-1:0]       o_m_axis_tdata,  // power_result[31:0]
    output logic                    o_m_axis_tuser   // bad_input[0]
);
    localparam int IDX_W = $clog2(MOD_BITS);

    typedef enum logic [2:0] {
        S_IDLE, S_RSTART, S_WAIT, S_EFIX, S_BIT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_EXP, PH_SQ, PH_MX
    } t_phase;

    t_state              r_state;
    t_phase              r_phase;
    logic [MOD_BITS-1:0] r_mod;
    logic [MOD_BITS-1:0] r_x;
    logic [MOD_BITS-1:0] r_e;
    logic [MOD_BITS-1:0] r_ans;
    logic [MOD_BITS-1:0] r_res;
    logic                r_bad;
    logic                r_neg;
    logic                r_started;
    logic [IDX_W-1:0]    r_i;
    logic [EXP_W-1:0]    r_dividend;
    logic [MOD_BITS-1:0] r_divisor;
    logic                r_ovalid;
    logic [DATA_W-1:0]   r_odata;
    logic                r_obad;

    logic [MOD_BITS-1:0]   w_meff;
    logic [MOD_BITS-1:0]   w_pm1;
    logic [DATA_W-1:0]     w_base;
    logic [EXP_W-1:0]      w_exp;
    logic [EXP_W-1:0]      w_mag;
    logic                  w_accept;
    logic                  w_red_done;
    logic [MOD_BITS-1:0]   w_rem;
    logic [MOD_BITS-1:0]   w_efix;
    logic [2*MOD_BITS-1:0] w_sq;
    logic [2*MOD_BITS-1:0] w_mx;
    logic                  w_out_bad;
    logic                  w_out_ok;

    assign w_meff   = (r_mod < MOD_BITS'(2)) ? MOD_BITS'(2) : r_mod;
    assign w_pm1    = w_meff - 1'b1;
    assign w_base   = i_s_axis_tdata[DATA_W-1:0];
    assign w_exp    = i_s_axis_tdata[DATA_W+EXP_W-1:DATA_W];
    assign w_mag    = w_exp[EXP_W-1] ? (~w_exp + 1'b1) : w_exp;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_efix   = (r_neg && (w_rem != '0)) ? (w_pm1 - w_rem) : w_rem;
    assign w_sq     = {{MOD_BITS{1'b0}}, r_ans} * {{MOD_BITS{1'b0}}, r_ans};
    assign w_mx     = {{MOD_BITS{1'b0}}, w_rem} * {{MOD_BITS{1'b0}}, r_x};

    pfp_modred #(
        .MOD_BITS (MOD_BITS)
    ) u_modred (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_RSTART),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_done     (w_red_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_BITS'(2);
        end else if (i_cfg_wr_en) begin
            r_mod <= i_cfg_wr_data[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_EXP;
            r_ovalid  <= 1'b0;
            r_started <= 1'b0;
            r_i       <= '0;
        end else begin
            if (r_ovalid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x   <= w_base[MOD_BITS-1:0];
                        r_neg <= w_exp[EXP_W-1];
                        if (w_base >= DATA_W'(w_meff)) begin
                            r_res   <= '0;
                            r_bad   <= 1'b1;
                            r_state <= S_OUT;
                        end else if (w_base == '0) begin
                            r_res   <= '0;
                            r_bad   <= w_exp[EXP_W-1] || (w_exp == '0);
                            r_state <= S_OUT;
                        end else if (w_base == DATA_W'(1)) begin
                            r_res   <= MOD_BITS'(1);
                            r_bad   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_bad      <= 1'b0;
                            r_dividend <= w_mag;
                            r_divisor  <= w_pm1;
                            r_phase    <= PH_EXP;
                            r_state    <= S_RSTART;
                        end
                    end
                end
                S_RSTART: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_red_done) begin
                        unique case (r_phase)
                            PH_EXP: begin
                                r_state <= S_EFIX;
                            end
                            PH_SQ: begin
                                r_ans <= w_rem;
                                if (r_e[r_i]) begin
                                    r_dividend <= EXP_W'(w_mx);
                                    r_phase    <= PH_MX;
                                    r_state    <= S_RSTART;
                                end else if (r_i == '0) begin
                                    r_res   <= w_rem;
                                    r_state <= S_OUT;
                                end else begin
                                    r_i     <= r_i - 1'b1;
                                    r_state <= S_BIT;
                                end
                            end
                            default: begin
                                r_ans <= w_rem;
                                if (r_i == '0) begin
                                    r_res   <= w_rem;
                                    r_state <= S_OUT;
                                end else begin
                                    r_i     <= r_i - 1'b1;
                                    r_state <= S_BIT;
                                end
                            end
                        endcase
                    end
                end
                S_EFIX: begin
                    if (w_efix == '0) begin
                        r_res   <= MOD_BITS'(1);
                        r_state <= S_OUT;
                    end else if (w_efix == MOD_BITS'(1)) begin
                        r_res   <= r_x;
                        r_state <= S_OUT;
                    end else begin
                        r_e       <= w_efix;
                        r_i       <= IDX_W'(MOD_BITS - 1);
                        r_started <= 1'b0;
                        r_divisor <= w_meff;
                        r_state   <= S_BIT;
                    end
                end
                S_BIT: begin
                    if (r_started) begin
                        r_dividend <= EXP_W'(w_sq);
                        r_phase    <= PH_SQ;
                        r_state    <= S_RSTART;
                    end else begin
                        if (r_e[r_i]) begin
                            r_started <= 1'b1;
                            r_ans     <= r_x;
                        end
                        if (r_i == '0) begin
                            r_res   <= r_x;
                            r_state <= S_OUT;
                        end else begin
                            r_i <= r_i - 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= DATA_W'(r_res);
                        r_obad   <= r_bad;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_obad;

    assign w_out_bad = o_m_axis_tvalid && o_m_axis_tuser;
    assign w_out_ok  = o_m_axis_tvalid && !o_m_axis_tuser;

    `include "assert_macros.svh"

    `PFP_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_s_axis_tready, "ready after accept")
    `PFP_ASSERT(a_bad_gives_zero, w_out_bad |-> (o_m_axis_tdata == '0), "bad with nonzero")
    `PFP_ASSERT(a_result_in_field, w_out_ok |-> (o_m_axis_tdata < DATA_W'(w_meff)), "not reduced")
endmodule
